// ===== hw/rtl/volume_restriction_3d_top_assert.svh =====
// assertion macros for the volume restriction block
`ifndef VOLUME_RESTRICTION_3D_TOP_ASSERT_SVH
`define VOLUME_RESTRICTION_3D_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define VR3D_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// next-cycle implication, checked outside reset
`define VR3D_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

// ===== hw/rtl/vr3d_pkg.sv =====
// shared types and constants of the volume restriction block
package vr3d_pkg;

    localparam int DIM_W = 10;

    typedef struct packed {
        logic [DIM_W-1:0] fsx;
        logic [DIM_W-1:0] fsy;
        logic [DIM_W-1:0] fsz;
        logic [DIM_W-1:0] cex;
        logic [DIM_W-1:0] cey;
        logic [DIM_W-1:0] cez;
    } vr3d_geom_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_TAP,
        B_LAST,
        B_PREP,
        B_DIV,
        B_OUT
    } vr3d_state_t;

    localparam logic [2:0] REG_FINE_X   = 3'd0;
    localparam logic [2:0] REG_FINE_Y   = 3'd1;
    localparam logic [2:0] REG_FINE_Z   = 3'd2;
    localparam logic [2:0] REG_COARSE_X = 3'd3;
    localparam logic [2:0] REG_COARSE_Y = 3'd4;
    localparam logic [2:0] REG_COARSE_Z = 3'd5;

    localparam logic [7:0] FINE_RESET   = 8'd128;
    localparam logic [6:0] COARSE_RESET = 7'd64;

endpackage

// ===== hw/rtl/volume_restriction_3d_top.sv =====
// top level of the 3-d full weighting restriction block
// - in channel (in_valid/in_ready/fine_sample): one fine Q16.16 voxel per beat,
//   raster order, x fastest, then y, then z; a new volume starts by itself
// - out channel (out_valid/out_ready/coarse_value/volume_end): one coarse voxel
//   per beat, volume_end marks the last coarse voxel of the volume
// - cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): fine sizes at
//   indexes 0..2, coarse sizes at 3..5; write only while the block is idle
// - a fine beat that completes no coarse voxel needs only a plane store write in
//   the back end; the queue takes one beat per cycle while it has room
// - a completing beat goes through the back end in order: the write,
//   27 tap reads from the single plane store read port, B_LAST and B_PREP to
//   finish the sum, SAMPLE_BITS + 6 rounding divider steps, the output register load
// - reset clears position, queue and control; sizes return to 128/128/128
//   and 64/64/64; the plane store is not cleared and needs none
// - when the receiver stalls, the result waits in the output register while
//   the back end goes on with queued beats; it stops only when a second
//   result is ready, and the in side stops once the queue is full
module volume_restriction_3d_top
    import vr3d_pkg::*;
#(
    parameter int MAX_FINE_DIM = 128,
    parameter int SAMPLE_BITS  = 32
)(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [SAMPLE_BITS-1:0] fine_sample,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [SAMPLE_BITS-1:0] coarse_value,
    output logic                   volume_end,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [2:0]             cfg_index,
    input  logic [7:0]             cfg_data
);

`include "volume_restriction_3d_top_assert.svh"

    localparam int PW    = $clog2(MAX_FINE_DIM);
    localparam int EW    = SAMPLE_BITS + 5 * PW + 5;
    localparam int DEPTH = 4;
    localparam int LW    = $clog2(DEPTH + 1);

    // configuration registers as written; coarse sizes keep only the low 7 bits
    logic [7:0] fsx_reg, fsy_reg, fsz_reg;
    logic [6:0] csx_reg, csy_reg, csz_reg;

    vr3d_geom_t geom;
    logic [DIM_W-1:0] fdx, fdy, fdz, hx, hy, hz;

    logic          push, pop, full, empty;
    logic [EW-1:0] q_in, q_out;
    logic [LW-1:0] level;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsx_reg <= FINE_RESET;
            fsy_reg <= FINE_RESET;
            fsz_reg <= FINE_RESET;
            csx_reg <= COARSE_RESET;
            csy_reg <= COARSE_RESET;
            csz_reg <= COARSE_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_FINE_X:   fsx_reg <= cfg_data;
                REG_FINE_Y:   fsy_reg <= cfg_data;
                REG_FINE_Z:   fsz_reg <= cfg_data;
                REG_COARSE_X: csx_reg <= cfg_data[6:0];
                REG_COARSE_Y: csy_reg <= cfg_data[6:0];
                REG_COARSE_Z: csz_reg <= cfg_data[6:0];
                default:      fsx_reg <= fsx_reg;
            endcase
        end
    end

    // saturate fine sizes to 1..MAX_FINE_DIM
    function automatic logic [DIM_W-1:0] fine_dim(input logic [7:0] raw);
        logic [DIM_W-1:0] v;
        v = DIM_W'(raw);
        if (v == '0)
        begin
            v = DIM_W'(1);
        end
        else if (v > DIM_W'(MAX_FINE_DIM))
        begin
            v = DIM_W'(MAX_FINE_DIM);
        end
        return v;
    endfunction

    assign fdx = fine_dim(fsx_reg);
    assign fdy = fine_dim(fsy_reg);
    assign fdz = fine_dim(fsz_reg);
    assign hx  = (fdx + 1'b1) >> 1;
    assign hy  = (fdy + 1'b1) >> 1;
    assign hz  = (fdz + 1'b1) >> 1;

    // coarse extent limited to what the fine volume can hold
    always_comb
    begin
        geom.fsx = fdx;
        geom.fsy = fdy;
        geom.fsz = fdz;
        geom.cex = (DIM_W'(csx_reg) < hx) ? DIM_W'(csx_reg) : hx;
        geom.cey = (DIM_W'(csy_reg) < hy) ? DIM_W'(csy_reg) : hy;
        geom.cez = (DIM_W'(csz_reg) < hz) ? DIM_W'(csz_reg) : hz;
    end

    vr3d_front #(
        .MAX_FINE_DIM (MAX_FINE_DIM),
        .SAMPLE_BITS  (SAMPLE_BITS),
        .PW           (PW),
        .EW           (EW)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .geom        (geom),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .fine_sample (fine_sample),
        .full        (full),
        .push        (push),
        .entry       (q_in)
    );

    vr3d_fifo #(
        .EW    (EW),
        .DEPTH (DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (q_in),
        .pop   (pop),
        .rdata (q_out),
        .full  (full),
        .empty (empty),
        .level (level)
    );

    vr3d_back #(
        .MAX_FINE_DIM (MAX_FINE_DIM),
        .SAMPLE_BITS  (SAMPLE_BITS),
        .PW           (PW),
        .EW           (EW)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .geom         (geom),
        .entry        (q_out),
        .empty        (empty),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .coarse_value (coarse_value),
        .volume_end   (volume_end)
    );

    // queue never overfills
    `VR3D_ASSERT_NOW(a_level_bound, clk, rst_n, 1'b1, level <= LW'(DEPTH))
    // an accepted beat sits in the queue on the next cycle
    `VR3D_ASSERT_NEXT(a_beat_queued, clk, rst_n, in_valid && in_ready, level != '0)
    // the back end never pops an empty queue
    `VR3D_ASSERT_NOW(a_no_underflow, clk, rst_n, pop, !empty)

endmodule

// ===== hw/rtl/vr3d_front.sv =====
// front end: accepts fine beats, tracks position, classifies completing voxels
module vr3d_front
    import vr3d_pkg::*;
#(
    parameter int MAX_FINE_DIM = 128,
    parameter int SAMPLE_BITS  = 32,
    parameter int PW           = 7,
    parameter int EW           = 64
)(
    input  logic                   clk,
    input  logic                   rst_n,
    input  vr3d_geom_t             geom,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [SAMPLE_BITS-1:0] fine_sample,
    input  logic                   full,
    output logic                   push,
    output logic [EW-1:0]          entry
);

    logic [PW-1:0] pos_x_reg, pos_y_reg, pos_z_reg;
    logic [PW-1:0] pos_x_next, pos_y_next, pos_z_next;
    logic [1:0]    zslot_reg, zslot_next;
    logic          wrap_x, wrap_y, wrap_z;
    logic          cmp_x, cmp_y, cmp_z;
    logic          end_x, end_y, end_z;
    logic [DIM_W-1:0] ex, ey, ez;

    assign ex = DIM_W'(pos_x_reg);
    assign ey = DIM_W'(pos_y_reg);
    assign ez = DIM_W'(pos_z_reg);

    assign wrap_x = (ex + 1'b1) >= geom.fsx;
    assign wrap_y = (ey + 1'b1) >= geom.fsy;
    assign wrap_z = (ez + 1'b1) >= geom.fsz;

    // an axis completes on odd positions, or on the high edge, inside the coarse extent
    // a position left past the extent by a size change completes nothing
    assign cmp_x = (pos_x_reg[0] || (ex + 1'b1) == geom.fsx) && (ex < geom.fsx)
                   && ((ex >> 1) < geom.cex);
    assign cmp_y = (pos_y_reg[0] || (ey + 1'b1) == geom.fsy) && (ey < geom.fsy)
                   && ((ey >> 1) < geom.cey);
    assign cmp_z = (pos_z_reg[0] || (ez + 1'b1) == geom.fsz) && (ez < geom.fsz)
                   && ((ez >> 1) < geom.cez);
    assign end_x = (ex >> 1) == (geom.cex - 1'b1);
    assign end_y = (ey >> 1) == (geom.cey - 1'b1);
    assign end_z = (ez >> 1) == (geom.cez - 1'b1);

    assign in_ready = !full;
    assign push     = in_valid && !full;

    assign entry = {fine_sample, pos_x_reg, pos_y_reg, zslot_reg, pos_z_reg[0],
                    PW'(pos_x_reg >> 1), PW'(pos_y_reg >> 1), PW'(pos_z_reg >> 1),
                    cmp_x && cmp_y && cmp_z, end_x && end_y && end_z};

    always_comb
    begin
        pos_x_next = pos_x_reg;
        pos_y_next = pos_y_reg;
        pos_z_next = pos_z_reg;
        zslot_next = zslot_reg;
        if (wrap_x)
        begin
            pos_x_next = '0;
            if (wrap_y)
            begin
                pos_y_next = '0;
                if (wrap_z)
                begin
                    pos_z_next = '0;
                    zslot_next = '0;
                end
                else
                begin
                    pos_z_next = pos_z_reg + 1'b1;
                    zslot_next = (zslot_reg == 2'd2) ? 2'd0 : zslot_reg + 2'd1;
                end
            end
            else
            begin
                pos_y_next = pos_y_reg + 1'b1;
            end
        end
        else
        begin
            pos_x_next = pos_x_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg <= '0;
            pos_y_reg <= '0;
            pos_z_reg <= '0;
            zslot_reg <= '0;
        end
        else if (push)
        begin
            pos_x_reg <= pos_x_next;
            pos_y_reg <= pos_y_next;
            pos_z_reg <= pos_z_next;
            zslot_reg <= zslot_next;
        end
    end

endmodule

// ===== hw/rtl/vr3d_fifo.sv =====
// short queue between front and back end
module vr3d_fifo
    import vr3d_pkg::*;
#(
    parameter int EW    = 64,
    parameter int DEPTH = 4
)(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [EW-1:0]              wdata,
    input  logic                       pop,
    output logic [EW-1:0]              rdata,
    output logic                       full,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] level
);

    localparam int AW = $clog2(DEPTH);

    logic [EW-1:0]              slot_reg [DEPTH];
    logic [AW-1:0]              wp_reg, rp_reg;
    logic [$clog2(DEPTH+1)-1:0] cnt_reg;

    assign full  = cnt_reg == ($clog2(DEPTH+1))'(DEPTH);
    assign empty = cnt_reg == '0;
    assign level = cnt_reg;
    assign rdata = slot_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wp_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            end
            if (pop)
            begin
                rp_reg <= (rp_reg == AW'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/vr3d_back.sv =====
// back end: plane store, tap walk, accumulation, rounding divide, output register
module vr3d_back
    import vr3d_pkg::*;
#(
    parameter int MAX_FINE_DIM = 128,
    parameter int SAMPLE_BITS  = 32,
    parameter int PW           = 7,
    parameter int EW           = 64
)(
    input  logic                   clk,
    input  logic                   rst_n,
    input  vr3d_geom_t             geom,
    input  logic [EW-1:0]          entry,
    input  logic                   empty,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [SAMPLE_BITS-1:0] coarse_value,
    output logic                   volume_end
);

    localparam int MEM_WORDS = 3 * MAX_FINE_DIM * MAX_FINE_DIM;
    localparam int MW        = $clog2(MEM_WORDS);
    localparam int TW        = PW + 2;
    localparam int AW        = SAMPLE_BITS + 5;
    localparam int NB        = AW + 1;
    localparam int CW        = $clog2(NB + 1);
    localparam logic [MW-1:0] PLANE_C = MW'(MAX_FINE_DIM * MAX_FINE_DIM);
    localparam logic [MW-1:0] ROW_C   = MW'(MAX_FINE_DIM);

    logic [SAMPLE_BITS-1:0] e_sample;
    logic [PW-1:0]          e_px, e_py, e_cx, e_cy, e_cz;
    logic [1:0]             e_zslot;
    logic                   e_podd, e_cmpl, e_end;

    assign {e_sample, e_px, e_py, e_zslot, e_podd, e_cx, e_cy, e_cz, e_cmpl, e_end} = entry;

    vr3d_state_t state_reg, state_next;

    logic [SAMPLE_BITS-1:0] mem [MEM_WORDS];
    logic [SAMPLE_BITS-1:0] rd_q_reg;
    logic [MW-1:0]          wr_addr, rd_addr;

    logic [PW-1:0] cx_reg, cy_reg, cz_reg;
    logic [1:0]    zslot_reg;
    logic          podd_reg, end_reg;
    logic [1:0]    di_reg, dj_reg, dk_reg;
    logic          tap_v_reg;
    logic [1:0]    tap_sh_reg;
    logic signed [AW-1:0] acc_reg;
    logic [4:0]    wsum_reg;
    logic [NB-1:0] num_reg;
    logic [6:0]    rem_reg;
    logic [CW-1:0] cnt_reg;
    logic          neg_reg;
    logic          ov_reg, ve_reg;
    logic [SAMPLE_BITS-1:0] cv_reg;

    // output decode
    logic do_write, do_start, do_issue, do_prep, do_div, do_load, last_tap;

    // tap geometry
    logic [TW-1:0] tx, ty, tz;
    logic          tap_ok;
    logic [1:0]    zeros;
    logic [2:0]    zs_raw;
    logic [1:0]    tslot;
    logic [7:0]    div_t;
    logic          div_bit;
    logic [AW-1:0] mag;
    logic [SAMPLE_BITS-1:0] q_mag, q_val;

    assign tx = TW'({cx_reg, 1'b0}) + TW'(di_reg);
    assign ty = TW'({cy_reg, 1'b0}) + TW'(dj_reg);
    assign tz = TW'({cz_reg, 1'b0}) + TW'(dk_reg);
    assign zeros = 2'(di_reg == 2'd1) + 2'(dj_reg == 2'd1) + 2'(dk_reg == 2'd1);
    assign tap_ok = (zeros != 2'd0)
        && (tx != '0) && (DIM_W'(tx) <= geom.fsx)
        && (ty != '0) && (DIM_W'(ty) <= geom.fsy)
        && (tz != '0) && (DIM_W'(tz) <= geom.fsz);

    // slot of plane tz relative to the slot of the completing plane
    assign zs_raw = 3'(zslot_reg) + 3'd2 + 3'(dk_reg) - 3'(podd_reg);
    always_comb
    begin
        if (zs_raw >= 3'd6)
        begin
            tslot = 2'(zs_raw - 3'd6);
        end
        else if (zs_raw >= 3'd3)
        begin
            tslot = 2'(zs_raw - 3'd3);
        end
        else
        begin
            tslot = 2'(zs_raw);
        end
    end

    assign wr_addr = MW'(e_zslot) * PLANE_C + MW'(e_py) * ROW_C + MW'(e_px);
    assign rd_addr = MW'(tslot) * PLANE_C + MW'(PW'(ty - 1'b1)) * ROW_C
                   + MW'(PW'(tx - 1'b1));
    assign last_tap = (di_reg == 2'd2) && (dj_reg == 2'd2) && (dk_reg == 2'd2);

    assign div_t   = {rem_reg, num_reg[NB-1]};
    assign div_bit = div_t >= {2'b00, wsum_reg, 1'b0};
    assign mag     = acc_reg[AW-1] ? AW'(-acc_reg) : AW'(acc_reg);
    assign q_mag   = num_reg[SAMPLE_BITS-1:0];
    assign q_val   = (wsum_reg == '0) ? '0 : (neg_reg ? SAMPLE_BITS'(-q_mag) : q_mag);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (!empty && e_cmpl)
                begin
                    state_next = B_TAP;
                end
            end
            B_TAP:
            begin
                if (last_tap)
                begin
                    state_next = B_LAST;
                end
            end
            B_LAST: state_next = B_PREP;
            B_PREP: state_next = B_DIV;
            B_DIV:
            begin
                if (cnt_reg == CW'(1))
                begin
                    state_next = B_OUT;
                end
            end
            B_OUT:
            begin
                if (!ov_reg || out_ready)
                begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        pop      = 1'b0;
        do_write = 1'b0;
        do_start = 1'b0;
        do_issue = 1'b0;
        do_prep  = 1'b0;
        do_div   = 1'b0;
        do_load  = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                pop      = !empty;
                do_write = !empty;
                do_start = !empty && e_cmpl;
            end
            B_TAP:  do_issue = 1'b1;
            B_PREP: do_prep  = 1'b1;
            B_DIV:  do_div   = 1'b1;
            B_OUT:  do_load  = !ov_reg || out_ready;
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            mem[wr_addr] <= e_sample;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_q_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (do_start)
        begin
            cx_reg    <= e_cx;
            cy_reg    <= e_cy;
            cz_reg    <= e_cz;
            zslot_reg <= e_zslot;
            podd_reg  <= e_podd;
            end_reg   <= e_end;
        end
        if (do_prep)
        begin
            neg_reg <= acc_reg[AW-1];
            num_reg <= NB'({mag, 1'b0}) + NB'(wsum_reg);
            rem_reg <= '0;
            cnt_reg <= CW'(NB);
        end
        else if (do_div)
        begin
            num_reg <= {num_reg[NB-2:0], div_bit};
            rem_reg <= div_bit ? 7'(div_t - {2'b00, wsum_reg, 1'b0}) : div_t[6:0];
            cnt_reg <= cnt_reg - 1'b1;
        end
        if (do_load)
        begin
            cv_reg <= q_val;
            ve_reg <= end_reg;
        end
        if (do_start)
        begin
            acc_reg  <= '0;
            wsum_reg <= '0;
        end
        else if (tap_v_reg)
        begin
            acc_reg  <= acc_reg + (AW'(signed'(rd_q_reg)) <<< tap_sh_reg);
            wsum_reg <= wsum_reg + (5'd1 << tap_sh_reg);
        end
        tap_sh_reg <= zeros - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            di_reg    <= '0;
            dj_reg    <= '0;
            dk_reg    <= '0;
            tap_v_reg <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            tap_v_reg <= do_issue && tap_ok;
            if (do_start)
            begin
                di_reg <= '0;
                dj_reg <= '0;
                dk_reg <= '0;
            end
            else if (do_issue)
            begin
                if (di_reg == 2'd2)
                begin
                    di_reg <= '0;
                    if (dj_reg == 2'd2)
                    begin
                        dj_reg <= '0;
                        dk_reg <= dk_reg + 2'd1;
                    end
                    else
                    begin
                        dj_reg <= dj_reg + 2'd1;
                    end
                end
                else
                begin
                    di_reg <= di_reg + 2'd1;
                end
            end
            if (do_load)
            begin
                ov_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    assign out_valid    = ov_reg;
    assign coarse_value = cv_reg;
    assign volume_end   = ve_reg;

endmodule

// ===== sim/tb_volume_restriction_3d_top.sv =====
// self-checking testbench of the 3-d full weighting restriction block
module tb_volume_restriction_3d_top;
    import vr3d_pkg::*;

    localparam int MAX_DIM = 128;
    localparam int IDLE_LIMIT = 20000;  // watchdog: cycles with no beat anywhere
    localparam int DRAIN_CYCLES = 200;  // back end latency plus queued no-result beats
    localparam int ITEM_GOAL = 1850;
    localparam int QUIET_FROM = 1600;   // no idling after this many fine beats
    localparam int HOLD_AT = 100;       // long receiver hold-off starts in the 8-cube row
    localparam int HOLD_CYCLES = 800;

    // coarse voxel expected on the out channel
    typedef struct {
        logic [31:0] value;
        logic        last;
    } coarse_beat_t;

    // one directed phase: register values, volume count, fill value of every
    // fine voxel (or random), and whether each coarse voxel must equal the fill
    typedef struct {
        int          sz[6];
        int          vols;
        logic [31:0] fill;
        bit          use_fill;
        bit          typed;
    } plan_row_t;

    localparam logic [2:0] REG_ORDER[6] = '{REG_FINE_X, REG_FINE_Y, REG_FINE_Z,
                                           REG_COARSE_X, REG_COARSE_Y, REG_COARSE_Z};

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] fine_sample;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] coarse_value;
    logic        volume_end;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [7:0]  cfg_data;

    volume_restriction_3d_top DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .fine_sample  (fine_sample),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .coarse_value (coarse_value),
        .volume_end   (volume_end),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // shadow of the block: three fine planes, raster position, size registers
    logic signed [31:0] plane_copy[3][MAX_DIM][MAX_DIM];
    int                 at_x;
    int                 at_y;
    int                 at_z;
    logic [7:0]         size_reg[6];

    coarse_beat_t coarse_due[$];
    int           mismatches;
    int           fine_sent;
    bit           quiet;

    // directed check: every predicted coarse voxel of the phase must equal this
    bit           typed_on;
    logic [31:0]  typed_value;

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int fine_ext(int a);
        int f;
        f = size_reg[a];
        if (f < 1) f = 1;
        if (f > MAX_DIM) f = MAX_DIM;
        return f;
    endfunction

    function automatic int coarse_ext(int a);
        int lim;
        int c;
        lim = (fine_ext(a) + 1) / 2;
        c = size_reg[a + 3] & 8'h7f;
        return (c < lim) ? c : lim;
    endfunction

    // coarse index along one axis that fine position p finishes, or -1
    function automatic int axis_done(int p, int fs, int ce);
        int v;
        v = -1;
        if (p >= fs) return -1;
        if (p & 1) v = (p - 1) / 2;
        else if (p == fs - 1) v = p / 2;
        if (v >= ce) v = -1;
        return v;
    endfunction

    task automatic report(string what, logic [31:0] exp_v, logic [31:0] got_v);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s: expected %h got %h at %0t", what, exp_v, got_v, $time);
    endtask

    // absorb one fine voxel, queue the coarse voxel it completes if any
    task automatic restrict_step(logic [31:0] sample);
        int fsx, fsy, fsz, cex, cey, cez, cx, cy, cz, tx, ty, tz, zeros;
        longint acc, wsum, mag, r, w;
        coarse_beat_t beat;
        fsx = fine_ext(0); fsy = fine_ext(1); fsz = fine_ext(2);
        cex = coarse_ext(0); cey = coarse_ext(1); cez = coarse_ext(2);
        plane_copy[at_z % 3][at_y][at_x] = sample;
        cx = axis_done(at_x, fsx, cex);
        cy = axis_done(at_y, fsy, cey);
        cz = axis_done(at_z, fsz, cez);
        if (cx >= 0 && cy >= 0 && cz >= 0)
        begin
            acc = 0;
            wsum = 0;
            for (int dk = -1; dk <= 1; dk++)
                for (int dj = -1; dj <= 1; dj++)
                    for (int di = -1; di <= 1; di++)
                    begin
                        zeros = (di == 0) + (dj == 0) + (dk == 0);
                        tx = 2 * cx + di;
                        ty = 2 * cy + dj;
                        tz = 2 * cz + dk;
                        // corners carry no weight, taps below or past the volume skipped
                        if (zeros != 0 && tx >= 0 && ty >= 0 && tz >= 0 &&
                            tx < fsx && ty < fsy && tz < fsz)
                        begin
                            w = longint'(1) << (zeros - 1);
                            acc += w * longint'(plane_copy[tz % 3][ty][tx]);
                            wsum += w;
                        end
                    end
            // round to nearest, ties away from zero
            mag = (acc < 0) ? -acc : acc;
            r = (wsum > 0) ? (2 * mag + wsum) / (2 * wsum) : 0;
            beat.value = (acc < 0) ? 32'(-r) : 32'(r);
            beat.last = (cx == cex - 1 && cy == cey - 1 && cz == cez - 1);
            if (typed_on && beat.value !== typed_value)
                report("directed value", typed_value, beat.value);
            coarse_due.push_back(beat);
        end
        if (at_x + 1 >= fsx)
        begin
            at_x = 0;
            if (at_y + 1 >= fsy)
            begin
                at_y = 0;
                at_z = (at_z + 1 >= fsz) ? 0 : at_z + 1;
            end
            else
                at_y++;
        end
        else
            at_x++;
    endtask

    // monitor: follow every accepted beat on all three channels
    always @(posedge clk)
    begin
        coarse_beat_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                size_reg[cfg_index] <= cfg_data;
            if (in_valid && in_ready)
                restrict_step(fine_sample);
            if (out_valid && out_ready)
            begin
                if (coarse_due.size() == 0)
                    report("unexpected beat", 32'hx, coarse_value);
                else
                begin
                    want = coarse_due.pop_front();
                    if (coarse_value !== want.value)
                        report("coarse_value", want.value, coarse_value);
                    if (volume_end !== want.last)
                        report("volume_end", 32'(want.last), 32'(volume_end));
                end
            end
        end
    end

    // watchdog on cycles where nothing moves
    always @(posedge clk)
    begin
        int still;
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
            || !rst_n)
            still = 0;
        else
            still++;
        if (still >= IDLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // receiver: random stall bursts, one long hold-off so the block backs up
    initial
    begin
        int burst;
        bit held;
        burst = 0;
        held = 0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!held && fine_sent >= HOLD_AT)
            begin
                held = 1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                out_ready <= 1'b1;
            end
            else if (quiet)
                out_ready <= 1'b1;
            else if (burst > 0)
                burst--;
            else if ($urandom_range(0, 3) == 0)
            begin
                burst = $urandom_range(1, 10) - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    task automatic send_fine(logic [31:0] sample);
        int gap;
        @(negedge clk);
        in_valid <= 1'b1;
        fine_sample <= sample;
        do @(posedge clk); while (!in_ready);
        fine_sent++;
        quiet = (fine_sent >= QUIET_FROM);
        // sender gap after the beat
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 10);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // let the block drain before touching registers, then write all six
    task automatic load_sizes(int sz[6]);
        @(negedge clk);
        in_valid <= 1'b0;
        while (coarse_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        for (int i = 0; i < 6; i++)
        begin
            @(negedge clk);
            cfg_valid <= 1'b1;
            cfg_index <= REG_ORDER[i];
            cfg_data <= 8'(sz[i]);
            do @(posedge clk); while (!cfg_ready);
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] random_sample();
        case ($urandom_range(0, 15))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic run_volumes(int vols, bit use_fill, logic [31:0] fill);
        int voxels;
        @(negedge clk);
        voxels = fine_ext(0) * fine_ext(1) * fine_ext(2);
        for (int v = 0; v < vols * voxels; v++)
            send_fine(use_fill ? fill : random_sample());
    endtask

    // directed rows: zero fine sizes, clamped coarse sizes, full-scale
    // constants, coarse size zero, an odd fine size, and a full 8-cube
    // with many results that backs up under the long receiver hold
    plan_row_t plan[6] = '{
        '{'{0, 0, 0, 1, 1, 1},       2, 32'h7fff_ffff, 1, 1},
        '{'{1, 1, 1, 127, 127, 127}, 2, 32'h8000_0000, 1, 1},
        '{'{2, 2, 2, 1, 1, 1},       1, 32'hffff_ffff, 1, 1},
        '{'{2, 2, 2, 0, 1, 1},       1, 32'h0,         0, 0},
        '{'{3, 1, 1, 2, 1, 1},       1, 32'h0,         0, 0},
        '{'{8, 8, 8, 4, 4, 4},       1, 32'h0,         0, 0}
    };

    initial
    begin
        int sz[6];
        int big;
        int vols;
        rst_n = 1'b0;
        in_valid = 1'b0;
        fine_sample = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_FINE_X;
        cfg_data = '0;
        mismatches = 0;
        fine_sent = 0;
        quiet = 0;
        typed_on = 0;
        typed_value = '0;
        at_x = 0;
        at_y = 0;
        at_z = 0;
        size_reg = '{FINE_RESET, FINE_RESET, FINE_RESET,
                     8'(COARSE_RESET), 8'(COARSE_RESET), 8'(COARSE_RESET)};
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (plan[i])
        begin
            load_sizes(plan[i].sz);
            typed_on = plan[i].typed;
            typed_value = plan[i].fill;
            run_volumes(plan[i].vols, plan[i].use_fill, plan[i].fill);
        end
        typed_on = 0;

        // random geometries: mostly tiny volumes, now and then one long axis
        while (fine_sent < ITEM_GOAL)
        begin
            big = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : -1;
            for (int a = 0; a < 3; a++)
            begin
                if (a == big)
                    case ($urandom_range(0, 2))
                        0: sz[a] = 128;
                        1: sz[a] = 129;
                        default: sz[a] = 255;
                    endcase
                else if (big >= 0)
                    sz[a] = $urandom_range(1, 2);
                else
                    sz[a] = $urandom_range(0, 7);
            end
            for (int a = 0; a < 3; a++)
            begin
                if ($urandom_range(0, 7) == 0)
                    sz[a + 3] = $urandom_range(0, 255);
                else
                    sz[a + 3] = $urandom_range(1, ((sz[a] > MAX_DIM ? MAX_DIM :
                        (sz[a] < 1 ? 1 : sz[a])) + 1) / 2);
            end
            vols = (big >= 0) ? 1 : $urandom_range(1, 3);
            load_sizes(sz);
            run_volumes(vols, 0, 32'h0);
        end

        // drain, then allow the back end to finish anything still in flight
        @(negedge clk);
        in_valid <= 1'b0;
        while (coarse_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && coarse_due.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
